// File: hdl/mbh_pkg.sv
// Shared constants and controller/datapath interface types for the
// multiplicative byte hash core. No dependencies.
`timescale 1ns / 1ps

package mbh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PendW = 24;
  localparam int unsigned PosW  = 2;
  localparam int unsigned ShW   = 5;

  localparam logic [HashW-1:0] MBH_MULT   = 32'hc6a4a793;
  localparam logic [ShW-1:0]   SHIFT_WORD = 5'd16;
  localparam logic [ShW-1:0]   SHIFT_TAIL = 5'd24;
  localparam logic [PosW-1:0]  POS_LAST   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture an accepted input transfer
    logic seed_mul;  // product <= length * multiplier
    logic seed_xor;  // hash <= seed ^ product, clear gathered bytes
    logic absorb;    // gather the latched byte, form a sum on a full word
    logic mul;       // product <= sum * multiplier
    logic mix;       // hash <= product ^ (product >> shift)
    logic tail_add;  // sum <= hash + gathered tail
    logic emit;      // load output register, clear gathered bytes
  } mbh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;  // latched length is zero
    logic pos_full;  // three bytes gathered, next completes a word
    logic pos_zero;  // no bytes gathered
    logic last;      // latched item ends the message
    logic tail;      // current multiply round is the tail round
    logic out_busy;  // output register holds a result not taken
  } mbh_sts_t;

endpackage

// File: hdl/mbh_datapath.sv
// Datapath of the multiplicative byte hash core: input capture, shared
// multiplier, running hash, byte gathering and output register. Uses mbh_pkg.
`timescale 1ns / 1ps

module mbh_datapath
  import mbh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HashW-1:0] cfg_wdata_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic [HashW-1:0] in_len_i,
  input  logic             in_last_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [HashW-1:0] out_hash_o,
  input  mbh_cmd_t         cmd_i,
  output mbh_sts_t         sts_o
);

  logic [HashW-1:0] seed_q;
  logic [ByteW-1:0] byte_q;
  logic [HashW-1:0] len_q;
  logic             last_q;
  logic [HashW-1:0] sum_q, sum_d;
  logic [HashW-1:0] prod_q, prod_d;
  logic [HashW-1:0] hash_q, hash_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             tail_q, tail_d;
  logic [HashW-1:0] out_q;
  logic             out_vld_q;
  logic [HashW-1:0] mul_a;
  logic [ShW-1:0]   mix_sh;

  assign mul_a  = cmd_i.seed_mul ? len_q : sum_q;
  assign prod_d = HashW'(mul_a * MBH_MULT);
  assign mix_sh = tail_q ? SHIFT_TAIL : SHIFT_WORD;

  always_comb begin
    sum_d  = sum_q;
    hash_d = hash_q;
    pend_d = pend_q;
    pos_d  = pos_q;
    tail_d = tail_q;
    if (cmd_i.seed_xor) begin
      hash_d = seed_q ^ prod_q;
      pend_d = '0;
      pos_d  = '0;
    end
    if (cmd_i.absorb) begin
      if (pos_q == POS_LAST) begin
        sum_d  = hash_q + {byte_q, pend_q};
        pend_d = '0;
        pos_d  = '0;
        tail_d = 1'b0;
      end else begin
        case (pos_q)
          2'd0:    pend_d[7:0]   = byte_q;
          2'd1:    pend_d[15:8]  = byte_q;
          default: pend_d[23:16] = byte_q;
        endcase
        pos_d = pos_q + 1'b1;
      end
    end
    if (cmd_i.tail_add) begin
      sum_d  = hash_q + {{(HashW-PendW){1'b0}}, pend_q};
      tail_d = 1'b1;
    end
    if (cmd_i.mix) begin
      hash_d = prod_q ^ (prod_q >> mix_sh);
    end
    if (cmd_i.emit) begin
      pend_d = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      pos_q     <= '0;
      pend_q    <= '0;
      out_vld_q <= 1'b0;
      tail_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      pend_q <= pend_d;
      tail_q <= tail_d;
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= in_byte_i;
      len_q  <= in_len_i;
      last_q <= in_last_i;
    end
    if (cmd_i.seed_mul || cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.emit) begin
      out_q <= hash_q;
    end
    sum_q  <= sum_d;
    hash_q <= hash_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_hash_o  = out_q;

  assign sts_o.len_zero = (len_q == '0);
  assign sts_o.pos_full = (pos_q == POS_LAST);
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.last     = last_q;
  assign sts_o.tail     = tail_q;
  assign sts_o.out_busy = out_vld_q & ~out_ready_i;

endmodule

// File: hdl/mbh_controller.sv
// Controller state machine of the multiplicative byte hash core: sequences
// seeding, word mixing, tail mixing and result hand-off. Uses mbh_pkg.
`timescale 1ns / 1ps

module mbh_controller
  import mbh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output mbh_cmd_t cmd_o,
  input  mbh_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_XOR,
    S_ABSORB,
    S_MUL,
    S_MIX,
    S_CHECK,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   inmsg_q, inmsg_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    inmsg_d = inmsg_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = inmsg_q ? S_ABSORB : S_SEED_MUL;
        end
      end
      S_SEED_MUL: begin
        cmd_o.seed_mul = 1'b1;
        state_d        = S_SEED_XOR;
      end
      S_SEED_XOR: begin
        cmd_o.seed_xor = 1'b1;
        inmsg_d        = 1'b1;
        state_d        = sts_i.len_zero ? S_CHECK : S_ABSORB;
      end
      S_ABSORB: begin
        cmd_o.absorb = 1'b1;
        state_d      = sts_i.pos_full ? S_MUL : S_CHECK;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = sts_i.tail ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (!sts_i.pos_zero) begin
          cmd_o.tail_add = 1'b1;
          state_d        = S_MUL;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          inmsg_d    = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inmsg_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inmsg_q <= inmsg_d;
    end
  end

endmodule

// File: hdl/multiplicative_byte_hash_core.sv
// Top level of the multiplicative byte hash core: stream ports, seed
// register port, controller and datapath. Uses mbh_pkg.
`timescale 1ns / 1ps

// Computes the 32-bit multiplicative byte hash over a message fed one byte
// per input transfer, with the message length carried on the first transfer
// and tlast marking the final one. The hash starts as seed xor (length times
// 0xc6a4a793); bytes gather little-endian into words, each word is added,
// multiplied and folded with a right shift of 16, and a one-to-three byte
// tail is added, multiplied and folded with a right shift of 24. One result
// transfer follows each message. A single 32x32 multiplier, registered after
// use, is shared by the seeding, word and tail rounds, and the controller
// walks one item at a time and takes no new transfer until the last is done:
// a plain byte is absorbed and checked, the byte that completes a word adds a
// multiply and mix round, the first item of a message adds the seeding steps
// (its byte is dropped when its length is zero), and a final item adds any
// tail round and the load of the output register, plus any wait while an
// earlier result is still held there. The output register lets the next
// message start while a result still waits on the master side.
module multiplicative_byte_hash_core
  import mbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register write
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [7:0] data_byte, [39:8] message_length
  input  logic        s_axis_tlast_i,   // end_of_message
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] hash_value
);

  mbh_cmd_t cmd;
  mbh_sts_t sts;

  // sequence one item through the shared multiplier
  mbh_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // hash state, multiplier and output register
  mbh_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i[7:0]),
    .in_len_i    (s_axis_tdata_i[39:8]),
    .in_last_i   (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_hash_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: bench/tb_multiplicative_byte_hash_core.sv
// Self-checking testbench for multiplicative_byte_hash_core: directed and random
// messages, a behavioral hash predictor and a result scoreboard.
// Depends only on the core RTL.
`timescale 1ns / 1ps

module tb_multiplicative_byte_hash_core;

  // Keep the multiplier independent of the package so a bad constant there shows up.
  localparam logic [31:0] HASH_MULT    = 32'hc6a4a793;
  localparam int          SETTLE_CYCLES = 20;
  // The limit covers the core's own sequencing of each item plus long sender gaps and receiver
  // stalls. Roughly 1000 items fit well below this limit.
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          PHASE_ITEMS   = 250;

  // One input transfer: tdata = {message_length, data_byte}, tlast = end_of_message.
  typedef struct packed {
    logic [31:0] msg_len;
    logic [7:0]  data;
    logic        eom;
  } byte_xfer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;

  byte_xfer_t  pend_q[$];       // transfers waiting to be driven
  logic [31:0] hash_exp_q[$];   // hashes still owed by the core
  logic        in_fire = 1'b0;  // input transfer happened at the last rising edge
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          accepted_items = 0;
  int          hashes_checked = 0;
  int          msg_count = 0;

  // Predictor state: seed copy, running hash and the partial little-endian word.
  logic [31:0] seed_copy = '0;
  logic [31:0] msg_hash = '0;
  logic [23:0] word_bytes = '0;
  logic [1:0]  word_count = '0;
  logic        msg_open = 1'b0;

  always #1 clk_i = ~clk_i;

  multiplicative_byte_hash_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // Add a word, multiply, and fold the high half down by the given shift.
  function automatic logic [31:0] mix_round(input logic [31:0] h, input logic [31:0] w,
                                            input int unsigned sh);
    logic [31:0] acc;
    acc = (h + w) * HASH_MULT;
    return acc ^ (acc >> sh);
  endfunction

  // Gather one byte; the fourth byte completes a word and mixes it in.
  function automatic void gather_byte(input logic [7:0] b);
    if (word_count == 2'd3) begin
      msg_hash   = mix_round(msg_hash, {b, word_bytes}, 16);
      word_bytes = '0;
      word_count = '0;
    end else begin
      word_bytes = word_bytes | (24'(b) << (8 * word_count));
      word_count = word_count + 2'd1;
    end
  endfunction

  // Advance the predictor by one accepted byte; return 1 with the hash on the final byte.
  function automatic bit hash_step(input byte_xfer_t x, output logic [31:0] digest);
    digest = '0;
    if (!msg_open) begin
      msg_hash   = seed_copy ^ (x.msg_len * HASH_MULT);
      word_bytes = '0;
      word_count = '0;
      msg_open   = 1'b1;
      // A zero length drops the byte carried by the opening transfer.
      if (x.msg_len != '0) gather_byte(x.data);
    end else begin
      gather_byte(x.data);
    end
    if (!x.eom) return 1'b0;
    digest = msg_hash;
    if (word_count != '0) digest = mix_round(digest, {8'h00, word_bytes}, 24);
    msg_hash   = '0;
    word_bytes = '0;
    word_count = '0;
    msg_open   = 1'b0;
    return 1'b1;
  endfunction

  // Queue one message: fill < 0 gives random bytes, else every byte is fill.
  task automatic push_message(input logic [31:0] len_field, input int n_xfers,
                              input int fill);
    byte_xfer_t x;
    for (int i = 0; i < n_xfers; i++) begin
      x.msg_len = len_field;
      x.data    = (fill < 0) ? 8'($urandom) : 8'(fill);
      x.eom     = (i == n_xfers - 1);
      pend_q.push_back(x);
    end
    msg_count++;
  endtask

  // Mostly well-formed messages with random content, plus zero-length and
  // length-mismatch messages.
  task automatic push_random_messages(input int n_items);
    int start;
    int pick;
    int n;
    start = pend_q.size();
    while (pend_q.size() - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        n = (pick < 70) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        push_message(n, n, -1);
      end else if (pick < 85) begin
        push_message(32'd0, 1, -1);
      end else if (pick < 93) begin
        push_message($urandom, $urandom_range(1, 9), -1);
      end else begin
        push_message(32'd0, $urandom_range(2, 7), -1);
      end
    end
  endtask

  // Hold until every transfer is in and every hash is out, then let the core settle.
  task automatic drain_and_settle();
    while (pend_q.size() != 0 || s_valid || hash_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the seed register while the core is idle and update the predictor copy.
  task automatic write_seed(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    seed_copy = v;
  endtask

  // Driver: change inputs on the falling edge. Advance to the next transfer once
  // the current one is taken, or insert a sender gap at random. Draw the
  // receiver stall anew every cycle.
  always @(negedge clk_i) begin
    if (!s_valid || in_fire) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_xfer_t x;
        x = pend_q.pop_front();
        s_data  <= {x.msg_len, x.data};
        s_last  <= x.eom;
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: sample both streams on the rising edge. Predict on input transfers
  // and check every result transfer against the oldest owed hash.
  always @(posedge clk_i) begin : monitor
    logic [31:0] digest;
    logic [31:0] exp_hash;
    in_fire <= s_valid && s_ready;
    if (s_valid && s_ready) begin
      accepted_items++;
      if (hash_step({s_data[39:8], s_data[7:0], s_last}, digest)) hash_exp_q.push_back(digest);
    end
    if (m_valid && m_ready) begin
      if (hash_exp_q.size() == 0) begin
        $error("hash_value transfer with nothing expected: got %08h", m_data);
        err_count++;
      end else begin
        exp_hash = hash_exp_q.pop_front();
        hashes_checked++;
        if (m_data !== exp_hash) begin
          $error("hash_value mismatch: expected %08h, got %08h", exp_hash, m_data);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a hang or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hashes still owed", cycle_count,
               hash_exp_q.size());
      $display("tb_multiplicative_byte_hash_core NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset seed and no idling: zero length (the hash
    // is just the seed), single bytes at both extremes, a three-byte tail, a
    // full word with no tail, a word plus a one-byte tail, a length that
    // disagrees with the byte count, and a zero length followed by more bytes.
    push_message(32'd0, 1, 8'hFF);
    push_message(32'd1, 1, 8'h00);
    push_message(32'd1, 1, 8'hFF);
    push_message(32'd3, 3, 8'hFF);
    push_message(32'd4, 4, 8'hFF);
    push_message(32'd5, 5, -1);
    push_message(32'hFFFF_FFFF, 2, -1);
    push_message(32'd0, 3, 8'hAA);
    drain_and_settle();

    // Random phases: no idling, sender gaps, receiver stalls, then both. Write a
    // new seed before each phase, with the extremes among the values.
    for (int p = 0; p < 4; p++) begin
      write_seed((p == 0) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0000_0000 : 32'($urandom));
      send_idle_pct  = (p == 1) ? 73 : (p == 3) ? 18 : 0;
      recv_stall_pct = (p == 2) ? 73 : (p == 3) ? 18 : 0;
      push_random_messages(PHASE_ITEMS);
      drain_and_settle();
    end

    $display("run covered %0d messages (%0d byte transfers) under four stall mixes",
             msg_count, accepted_items);
    $display("%0d hashes compared, %0d mismatches", hashes_checked, err_count);
    if (err_count == 0) begin
      $display("tb_multiplicative_byte_hash_core OK");
    end else begin
      $display("tb_multiplicative_byte_hash_core NOT OK");
    end
    $finish;
  end

endmodule

// File: multiplicative_byte_hash_core.f
hdl/mbh_pkg.sv
hdl/mbh_datapath.sv
hdl/mbh_controller.sv
hdl/multiplicative_byte_hash_core.sv
bench/tb_multiplicative_byte_hash_core.sv
